// ===== src/mss_pkg.sv =====
// Shared types, constants and helper functions for the move score sorter.
// Has no dependencies; every other file of the block imports it.
`default_nettype none

package mss_pkg;

  // Field widths of the request and result transactions.
  localparam int unsigned CODE_W   = 16;
  localparam int unsigned KIND_W   = 3;
  localparam int unsigned MKIND_W  = 2;
  localparam int unsigned VALUE_W  = 16;
  localparam int unsigned SCORE_W  = 18;

  // Configuration port geometry: six 32-bit registers at 4-byte spacing.
  localparam int unsigned NUM_PIECES = 6;
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned APB_ADDR_W = 5;
  localparam int unsigned REG_IDX_W  = 3;

  // Register indexes, which are also the piece kind codes.
  localparam logic [REG_IDX_W-1:0] REG_PAWN   = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_KNIGHT = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_BISHOP = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_ROOK   = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_QUEEN  = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_KING   = 3'd5;

  // Request types.
  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_FETCH = 1'b1;

  // Move kinds.
  localparam logic [MKIND_W-1:0] MK_NORMAL     = 2'd0;
  localparam logic [MKIND_W-1:0] MK_PROMOTION  = 2'd1;
  localparam logic [MKIND_W-1:0] MK_EN_PASSANT = 2'd2;
  localparam logic [MKIND_W-1:0] MK_CASTLING   = 2'd3;

  // Bonus added for a capture or an en passant move.
  localparam logic [SCORE_W-1:0] CAPTURE_BONUS = 18'd10;

  // Piece value table, index 0 is the pawn.
  typedef logic [NUM_PIECES-1:0][VALUE_W-1:0] piece_vals_t;

  localparam piece_vals_t PIECE_RESET = {
    16'd20000, 16'd900, 16'd500, 16'd330, 16'd320, 16'd100
  };

  // One stored move of the sorted list.
  typedef struct packed {
    logic [CODE_W-1:0]  code;
    logic [SCORE_W-1:0] score;
  } entry_t;

  // Command broadcast to every cell of the chain in a cycle.
  typedef struct packed {
    logic               load;
    logic               fetch;
    logic [CODE_W-1:0]  code;
    logic [SCORE_W-1:0] score;
  } cell_cmd_t;

  // Value of a piece kind; the unused codes count as zero.
  function automatic logic [VALUE_W-1:0] kind_value(input logic [KIND_W-1:0] kind,
                                                    input piece_vals_t      vals);
    logic [VALUE_W-1:0] val;
    val = '0;
    if (kind < KIND_W'(NUM_PIECES)) begin
      val = vals[kind];
    end
    return val;
  endfunction

endpackage

`default_nettype wire

// ===== src/mss_if.sv =====
// Valid/ready channel interfaces for the request and result transactions.
// Depends on mss_pkg for the field widths.
`default_nettype none

interface mss_req_if;
  import mss_pkg::*;

  logic                valid;
  logic                ready;
  logic                req_type;
  logic [CODE_W-1:0]   move_code;
  logic [KIND_W-1:0]   mover_kind;
  logic                target_occupied;
  logic [MKIND_W-1:0]  move_kind;
  logic [KIND_W-1:0]   promo_kind;
  logic                final_load;

  modport source (
    output valid, req_type, move_code, mover_kind, target_occupied, move_kind,
           promo_kind, final_load,
    input  ready
  );

  modport sink (
    input  valid, req_type, move_code, mover_kind, target_occupied, move_kind,
           promo_kind, final_load,
    output ready
  );
endinterface

interface mss_res_if;
  import mss_pkg::*;

  logic                valid;
  logic                ready;
  logic [CODE_W-1:0]   out_move_code;
  logic [SCORE_W-1:0]  move_score;
  logic                last_of_list;
  logic                list_empty;
  logic                dropped_any;

  modport source (
    output valid, out_move_code, move_score, last_of_list, list_empty, dropped_any,
    input  ready
  );

  modport sink (
    input  valid, out_move_code, move_score, last_of_list, list_empty, dropped_any,
    output ready
  );
endinterface

`default_nettype wire

// ===== src/mss_cfg_regs.sv =====
// APB-style configuration registers holding the six piece values.
// Depends on mss_pkg for the register map and the reset values.
`default_nettype none

module mss_cfg_regs (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [mss_pkg::APB_ADDR_W-1:0]     paddr,
  input  wire logic [mss_pkg::APB_DATA_W-1:0]     pwdata,
  output logic      [mss_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                    pready,
  output mss_pkg::piece_vals_t                    piece_vals_o
);
  import mss_pkg::*;

  piece_vals_t            vals_q, vals_d;
  logic [REG_IDX_W-1:0]   reg_idx;
  logic                   idx_ok;

  // Registers sit on word boundaries; the low address bits are ignored.
  assign reg_idx = paddr[APB_ADDR_W-1:2];
  assign idx_ok  = (reg_idx < REG_IDX_W'(NUM_PIECES));
  assign pready  = 1'b1;

  // A write lands in the access phase; unmapped addresses are ignored.
  always_comb begin
    vals_d = vals_q;
    if (psel && penable && pwrite && idx_ok) begin
      vals_d[reg_idx] = pwdata[VALUE_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vals_q <= PIECE_RESET;
    end else begin
      vals_q <= vals_d;
    end
  end

  // Read back the addressed register, zero for unmapped addresses.
  always_comb begin
    prdata = '0;
    if (idx_ok) begin
      prdata = APB_DATA_W'(vals_q[reg_idx]);
    end
  end

  assign piece_vals_o = vals_q;

endmodule

`default_nettype wire

// ===== src/mss_cell.sv =====
// One cell of the insertion chain: holds one move and its score.
// Depends on mss_pkg for the entry and command types.
`default_nettype none

module mss_cell (
  input  wire logic               clk_i,
  input  wire mss_pkg::cell_cmd_t cmd_i,
  input  wire logic               occupied_i,
  input  wire logic               prev_keep_i,
  input  wire mss_pkg::entry_t    prev_i,
  input  wire mss_pkg::entry_t    next_i,
  output logic                    keep_o,
  output mss_pkg::entry_t         entry_o
);
  import mss_pkg::*;

  entry_t entry_q, entry_d;

  // A held move stays put when it scores at least as high as the new one,
  // which keeps equal scores in load order.
  assign keep_o = occupied_i && (entry_q.score >= cmd_i.score);

  // On a load the cell keeps its move, takes the new one, or takes its
  // upper neighbour's move as the list opens a gap. On a fetch the list
  // moves up by one place.
  always_comb begin
    entry_d = entry_q;
    if (cmd_i.load) begin
      if (!keep_o) begin
        if (prev_keep_i) begin
          entry_d.code  = cmd_i.code;
          entry_d.score = cmd_i.score;
        end else begin
          entry_d = prev_i;
        end
      end
    end else if (cmd_i.fetch) begin
      entry_d = next_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

`default_nettype wire

// ===== src/move_score_sorter.sv =====
// Move score sorter top level. A transaction passes through the scoring
// register and then the cell chain; a fetch result is then held in the
// result register. One transaction per cycle is sustained, set by the single
// broadcast insert or shift of the cell chain; a held result stalls fetches.
// Reset empties the list, clears seal and overflow, and restores piece values.
// Depends on mss_pkg, mss_if, mss_cfg_regs and mss_cell.
`default_nettype none

module move_score_sorter #(
  parameter int unsigned MAX_MOVES = 256
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  mss_req_if.sink                                 req_i,
  mss_res_if.source                               res_o,
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [mss_pkg::APB_ADDR_W-1:0]     paddr,
  input  wire logic [mss_pkg::APB_DATA_W-1:0]     pwdata,
  output logic      [mss_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                    pready
);
  import mss_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_MOVES + 1);

  piece_vals_t          piece_vals;

  // Scoring stage.
  logic                 a_valid_q, a_valid_d;
  logic                 a_type_q;
  logic [CODE_W-1:0]    a_code_q;
  logic [SCORE_W-1:0]   a_score_q;
  logic                 a_final_q;
  logic [SCORE_W-1:0]   score_in;
  logic                 capture;

  // List control.
  logic [CNT_W-1:0]     count_q, count_d;
  logic [CNT_W-1:0]     eff_count;
  logic                 sealed_q, sealed_d;
  logic                 ovf_q, ovf_d;
  logic                 full;
  logic                 fetch_hit;
  logic                 b_fire;
  logic                 in_fire;

  // Result register.
  logic                 out_valid_q, out_valid_d;
  logic [CODE_W-1:0]    out_code_q;
  logic [SCORE_W-1:0]   out_score_q;
  logic                 out_last_q;
  logic                 out_empty_q;
  logic                 out_drop_q;

  // Cell chain.
  cell_cmd_t                  cmd;
  entry_t                     ent [MAX_MOVES];
  logic [MAX_MOVES-1:0]       keep;

  mss_cfg_regs u_cfg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .piece_vals_o (piece_vals)
  );

  // Score of the incoming move.
  assign capture  = (req_i.move_kind == MK_EN_PASSANT) || req_i.target_occupied;
  assign score_in = SCORE_W'(kind_value(req_i.mover_kind, piece_vals))
                  + (capture ? CAPTURE_BONUS : '0)
                  + ((req_i.move_kind == MK_PROMOTION)
                     ? SCORE_W'(kind_value(req_i.promo_kind, piece_vals)) : '0);

  // The chain stage always advances on a load; a fetch needs a free result slot.
  assign b_fire      = a_valid_q && ((a_type_q == REQ_LOAD) || !out_valid_q || res_o.ready);
  assign req_i.ready = !a_valid_q || b_fire;
  assign in_fire     = req_i.valid && req_i.ready;

  always_comb begin
    a_valid_d = a_valid_q;
    if (in_fire) begin
      a_valid_d = 1'b1;
    end else if (b_fire) begin
      a_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else begin
      a_valid_q <= a_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      a_type_q  <= req_i.req_type;
      a_code_q  <= req_i.move_code;
      a_score_q <= score_in;
      a_final_q <= req_i.final_load;
    end
  end

  // A load into a sealed list starts a fresh one.
  assign eff_count = sealed_q ? '0 : count_q;
  assign full      = (eff_count >= CNT_W'(MAX_MOVES));
  assign fetch_hit = sealed_q && (count_q != '0);

  always_comb begin
    cmd.load  = b_fire && (a_type_q == REQ_LOAD) && !full;
    cmd.fetch = b_fire && (a_type_q == REQ_FETCH) && fetch_hit;
    cmd.code  = a_code_q;
    cmd.score = a_score_q;
  end

  // List bookkeeping: count of held moves, seal and overflow flags.
  always_comb begin
    count_d  = count_q;
    sealed_d = sealed_q;
    ovf_d    = ovf_q;
    if (b_fire && (a_type_q == REQ_LOAD)) begin
      count_d  = eff_count;
      ovf_d    = sealed_q ? 1'b0 : ovf_q;
      if (full) begin
        ovf_d = 1'b1;
      end else begin
        count_d = eff_count + 1'b1;
      end
      sealed_d = a_final_q;
    end else if (cmd.fetch) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      sealed_q <= 1'b0;
      ovf_q    <= 1'b0;
    end else begin
      count_q  <= count_d;
      sealed_q <= sealed_d;
      ovf_q    <= ovf_d;
    end
  end

  // Row of cells; cell zero holds the best move.
  for (genvar i = 0; i < MAX_MOVES; i++) begin : g_cell
    logic   occupied;
    logic   prev_keep;
    entry_t prev_ent;
    entry_t next_ent;

    assign occupied = (CNT_W'(i) < eff_count);

    if (i == 0) begin : g_head
      assign prev_keep = 1'b1;
      assign prev_ent  = '0;
    end else begin : g_body
      assign prev_keep = keep[i-1];
      assign prev_ent  = ent[i-1];
    end

    if (i == MAX_MOVES - 1) begin : g_tail
      assign next_ent = '0;
    end else begin : g_inner
      assign next_ent = ent[i+1];
    end

    mss_cell u_cell (
      .clk_i       (clk_i),
      .cmd_i       (cmd),
      .occupied_i  (occupied),
      .prev_keep_i (prev_keep),
      .prev_i      (prev_ent),
      .next_i      (next_ent),
      .keep_o      (keep[i]),
      .entry_o     (ent[i])
    );
  end

  // Result register: every fetch yields one transaction.
  always_comb begin
    out_valid_d = out_valid_q;
    if (b_fire && (a_type_q == REQ_FETCH)) begin
      out_valid_d = 1'b1;
    end else if (res_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_fire && (a_type_q == REQ_FETCH)) begin
      if (fetch_hit) begin
        out_code_q  <= ent[0].code;
        out_score_q <= ent[0].score;
        out_last_q  <= (count_q == CNT_W'(1));
        out_empty_q <= 1'b0;
        out_drop_q  <= ovf_q;
      end else begin
        out_code_q  <= '0;
        out_score_q <= '0;
        out_last_q  <= 1'b0;
        out_empty_q <= 1'b1;
        out_drop_q  <= 1'b0;
      end
    end
  end

  assign res_o.valid         = out_valid_q;
  assign res_o.out_move_code = out_code_q;
  assign res_o.move_score    = out_score_q;
  assign res_o.last_of_list  = out_last_q;
  assign res_o.list_empty    = out_empty_q;
  assign res_o.dropped_any   = out_drop_q;

  // The list never holds more moves than there are cells.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_MOVES))
    else $error("move count exceeds the number of cells");

  // A fetch that finds a move removes exactly one from the list.
  a_fetch_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.fetch |=> (count_q == $past(count_q) - 1'b1))
    else $error("fetch did not remove exactly one move");

  // The two best held moves are in descending score order.
  a_head_sorted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q >= CNT_W'(2)) |-> (ent[0].score >= ent[1].score))
    else $error("head of the list is out of order");

  // A fetch never overwrites a result that is still waiting.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !res_o.ready) |=> (out_valid_q && $stable(out_code_q)
                                       && $stable(out_score_q)))
    else $error("pending result was overwritten");

endmodule

`default_nettype wire
